// ===== rtl/lmt_pkg.sv =====
// shared types, constants and functions of the led matrix text renderer
// no dependencies; imported by every module of the block
`default_nettype none

package lmt_pkg;

    // strip geometry
    localparam int COLUMNS = 22;
    localparam int ROWS    = 5;
    localparam int GLYPH_W = 5;
    localparam int DOTS    = ROWS * GLYPH_W;

    // width of an on-strip column value
    localparam int COL_W = $clog2(COLUMNS + 1);

    // led index field width and per-row index step, wrapping at 7 bits
    localparam int IDX_W = 7;
    localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(COLUMNS % 128);

    // register widths and reset values
    localparam int OFS_W = 11;
    localparam int LVL_W = 8;
    localparam logic [OFS_W-1:0] START_OFFSET_RST   = '0;
    localparam logic [LVL_W-1:0] LIT_BRIGHTNESS_RST = 8'd128;

    // register indexes on the configuration port
    localparam logic REG_START_OFFSET   = 1'b0;
    localparam logic REG_LIT_BRIGHTNESS = 1'b1;

    // character codes and placement steps
    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam int SPACE_ADV = 4;
    localparam int GLYPH_GAP = 2;

    // one rendering job passed from the front to the back
    typedef struct packed {
        logic [DOTS-1:0]  glyph;
        logic [2:0]       col_lo;
        logic [2:0]       col_hi;
        logic [COL_W-1:0] xc_lo;
    } lmt_job_t;

    // saturate an 18-bit signed value to the signed 16-bit range
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // fixed 5x5 glyph rom, lsb first, row-major
    function automatic logic [DOTS-1:0] glyph_rom(input logic [7:0] code);
        logic [DOTS-1:0] g;
        case (code)
            8'd65:   g = 25'h118FE2E; // A
            8'd66:   g = 25'h0F8BE2F;
            8'd67:   g = 25'h1E0843E;
            8'd68:   g = 25'h0F8C62F;
            8'd69:   g = 25'h1F0BC3F;
            8'd70:   g = 25'h010BC3F;
            8'd71:   g = 25'h1EC862E;
            8'd72:   g = 25'h118FE31;
            8'd73:   g = 25'h0108421;
            8'd74:   g = 25'h0E8C210;
            8'd33:   g = 25'h0100421; // !
            8'd75:   g = 25'h0928CA9;
            8'd76:   g = 25'h1F08421;
            8'd77:   g = 25'h118D771;
            8'd78:   g = 25'h11CD671;
            8'd79:   g = 25'h0E8C62E;
            8'd80:   g = 25'h010BE2F;
            8'd81:   g = 25'h164C62E;
            8'd82:   g = 25'h118BE2F;
            8'd83:   g = 25'h0F8383E;
            8'd84:   g = 25'h042109F;
            8'd85:   g = 25'h0E8C631;
            8'd86:   g = 25'h0454631;
            8'd88:   g = 25'h1151151;
            8'd89:   g = 25'h0421151;
            8'd90:   g = 25'h1F1111F; // Z
            8'd48:   g = 25'h0F4A52F; // 0
            8'd49:   g = 25'h0210843;
            8'd50:   g = 25'h0F0BD0F;
            8'd51:   g = 25'h0F43D0F;
            8'd52:   g = 25'h0843D29;
            8'd53:   g = 25'h0F43C2F;
            8'd54:   g = 25'h0F4BC2F;
            8'd55:   g = 25'h084210F;
            8'd56:   g = 25'h0F4BD2F;
            8'd57:   g = 25'h0843D2F; // 9
            8'd58:   g = 25'h0008020; // :
            8'd46:   g = 25'h0100000; // .
            8'd47:   g = 25'h0011100; // /
            8'd176:  g = 25'h0001926;
            8'd133:  g = 25'h097A4C6;
            8'd132:  g = 25'h097A4C9;
            8'd150:  g = 25'h064A4C9;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/led_matrix_text_renderer.sv =====
// top level of the led matrix text renderer: register port, front, queue, back
// depends on lmt_pkg, lmt_front, lmt_queue, lmt_back
//
// channel   direction  fields
// s_        in         tdata[7:0] char_code, tuser text_start
// m_        out        tdata[6:0] led_index, tdata[14:7] blue_level, tlast last_write
// apb       in/out     reg 0 start_offset at 0x0, reg 1 lit_brightness at 0x4
//
// a character is accepted while the job queue has room; its pixel writes then
// leave one per cycle while m_tready is high, up to 25 (5 rows times the
// on-strip glyph columns), paced by the back part's dot walker. a space or a
// fully off-strip glyph yields no write. a two-entry job queue lets the input
// run two jobs ahead of a stalled output. reset is synchronous, active low.
`default_nettype none

module led_matrix_text_renderer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] text_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [6:0] led_index, [14:7] blue_level
    output logic             m_tlast,   // last_write
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lmt_pkg::*;

    logic [OFS_W-1:0] start_offset_reg;
    logic [LVL_W-1:0] lit_brightness_reg;
    logic             wr_en;

    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    lmt_job_t fq_job, qb_job;

    // register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_offset_reg   <= START_OFFSET_RST;
            lit_brightness_reg <= LIT_BRIGHTNESS_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_START_OFFSET:   start_offset_reg   <= pwdata[OFS_W-1:0];
                REG_LIT_BRIGHTNESS: lit_brightness_reg <= pwdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[2])
            REG_START_OFFSET:   prdata = 32'(start_offset_reg);
            REG_LIT_BRIGHTNESS: prdata = 32'(lit_brightness_reg);
            default:            prdata = '0;
        endcase
    end

    lmt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .start_offset (start_offset_reg),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    lmt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    lmt_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (qb_valid),
        .job_ready      (qb_ready),
        .job            (qb_job),
        .lit_brightness (lit_brightness_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/lmt_front.sv =====
// front part: accepts characters, updates pen and highest column, builds jobs
// depends on lmt_pkg
`default_nettype none

module lmt_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] char_code
    input  wire logic                        s_tuser,   // [0] text_start
    input  wire logic [lmt_pkg::OFS_W-1:0]   start_offset,
    output logic                             job_valid,
    input  wire logic                        job_ready,
    output lmt_pkg::lmt_job_t                job
);
    import lmt_pkg::*;

    logic signed [15:0] pen_reg, pen_next;
    logic signed [15:0] high_reg, high_next;

    logic signed [15:0] p0, h0, h1;
    logic signed [17:0] cand;
    logic signed [17:0] xc [GLYPH_W];
    logic [GLYPH_W-1:0] col_valid;
    logic [GLYPH_W-1:0] col_lit;
    logic [DOTS-1:0]    g;
    logic [2:0]         max_col, lo, hi;
    logic               accept, is_space;

    localparam logic signed [17:0] COLS_S = 18'(COLUMNS);

    assign s_tready = job_ready;
    assign accept   = s_tvalid && s_tready;
    assign g        = glyph_rom(s_tdata);
    assign is_space = (s_tdata == SPACE_CODE);

    // starting pen and highest column, optionally reloaded
    assign p0 = s_tuser ? 16'(signed'(start_offset)) : pen_reg;
    assign h0 = s_tuser ? 16'(signed'(start_offset)) : high_reg;

    // lit columns of the glyph and the rightmost one
    always_comb begin
        col_lit = '0;
        for (int c = 0; c < GLYPH_W; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                col_lit[c] = col_lit[c] | g[r*GLYPH_W + c];
            end
        end
        max_col = '0;
        for (int c = 0; c < GLYPH_W; c++) begin
            if (col_lit[c]) max_col = 3'(c);
        end
    end

    // on-strip columns and their range
    always_comb begin
        lo = '0;
        hi = '0;
        for (int c = 0; c < GLYPH_W; c++) begin
            xc[c]        = 18'(p0) + 18'(c);
            col_valid[c] = (xc[c] >= 18'sd0) && (xc[c] < COLS_S);
        end
        for (int c = GLYPH_W - 1; c >= 0; c--) begin
            if (col_valid[c]) lo = 3'(c);
        end
        for (int c = 0; c < GLYPH_W; c++) begin
            if (col_valid[c]) hi = 3'(c);
        end
    end

    // placement update
    always_comb begin
        cand = 18'(p0) + 18'(max_col);
        if (is_space) begin
            h1       = sat16(18'(h0) + 18'(SPACE_ADV));
            pen_next = h1;
        end else begin
            h1 = ((|col_lit) && (cand > 18'(h0))) ? sat16(cand) : h0;
            pen_next = (h1 >= p0) ? sat16(18'(h1) + 18'(GLYPH_GAP)) : p0;
        end
        high_next = h1;
    end

    // job for the back part
    always_comb begin
        job.glyph  = g;
        job.col_lo = lo;
        job.col_hi = hi;
        job.xc_lo  = COL_W'(18'(p0) + 18'(lo));
        job_valid  = s_tvalid && !is_space && (|col_valid);
    end

    // placement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg  <= '0;
            high_reg <= '0;
        end else if (accept) begin
            pen_reg  <= pen_next;
            high_reg <= high_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lmt_queue.sv =====
// two-entry job queue between the front and the back part
// depends on lmt_pkg
`default_nettype none

module lmt_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lmt_pkg::lmt_job_t in_job,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lmt_pkg::lmt_job_t      out_job
);
    import lmt_pkg::*;

    lmt_job_t   entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        if (pop && !push) count_next = count_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= in_job;
    end

endmodule

`default_nettype wire

// ===== rtl/lmt_back.sv =====
// back part: walks the on-strip dots of a job and issues pixel writes
// depends on lmt_pkg
`default_nettype none

module lmt_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      job_valid,
    output logic                           job_ready,
    input  wire lmt_pkg::lmt_job_t         job,
    input  wire logic [lmt_pkg::LVL_W-1:0] lit_brightness,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [15:0]                    m_tdata,   // [6:0] led_index, [14:7] blue_level
    output logic                           m_tlast    // last_write
);
    import lmt_pkg::*;

    lmt_job_t         job_reg;
    logic             busy_reg;
    logic [2:0]       row_reg, col_reg;
    logic [COL_W-1:0] xc_reg;
    logic [IDX_W-1:0] base_reg;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             m_tlast_reg;

    logic             step, last, load;
    logic [COL_W-1:0] pos;
    logic [4:0]       dot;
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] blue;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
    localparam logic [2:0]       ROW_LAST = 3'(ROWS - 1);

    assign step      = busy_reg && (!m_tvalid_reg || m_tready);
    assign last      = (row_reg == ROW_LAST) && (col_reg == job_reg.col_hi);
    assign load      = !busy_reg || (step && last);
    assign job_ready = load;

    // current pixel
    always_comb begin
        pos  = row_reg[0] ? (COL_MAX - xc_reg) : xc_reg;
        idx  = base_reg + IDX_W'(pos);
        dot  = 5'({row_reg, 2'b00}) + 5'(row_reg) + 5'(col_reg);
        blue = job_reg.glyph[dot] ? lit_brightness : '0;
    end

    // dot walker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && job_valid) begin
            job_reg  <= job;
            row_reg  <= '0;
            col_reg  <= job.col_lo;
            xc_reg   <= job.xc_lo;
            base_reg <= '0;
        end else if (step) begin
            if (col_reg == job_reg.col_hi) begin
                row_reg  <= row_reg + 3'd1;
                col_reg  <= job_reg.col_lo;
                xc_reg   <= job_reg.xc_lo;
                base_reg <= base_reg + ROW_STEP;
            end else begin
                col_reg <= col_reg + 3'd1;
                xc_reg  <= xc_reg + COL_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {1'b0, blue, idx};
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire
